### rtl/http_chunked_body_decoder_assert.svh
// Assertion macros used by the chunked body decoder top level.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

### rtl/hcbd_pkg.sv
// Types and constants shared by the chunked body decoder modules.
`default_nettype none
package hcbd_pkg;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic [2:0] ST_DATA         = 3'd0;
    localparam logic [2:0] ST_FINISHED     = 3'd1;
    localparam logic [2:0] ST_NO_SIZE_TERM = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE     = 3'd3;
    localparam logic [2:0] ST_TRUNCATED    = 3'd4;
    localparam logic [2:0] ST_NO_DATA_TERM = 3'd5;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       end_of_body;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       last;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_class;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_CR,
        PH_EXT,
        PH_EXT_CR,
        PH_DATA,
        PH_TERM1,
        PH_TERM2
    } t_phase;

endpackage
`default_nettype wire

### rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder.
//
// Input channel: one body byte per item with an end-of-body flag, under
// i_in_valid and o_in_stall. Output channel: one payload byte or status per
// item, under o_out_valid and i_out_stall.
// Each byte causes at most one output item. Data bytes come out with status
// zero; a finish or an error comes out once, after which bytes are dropped
// until the end-of-body byte, which returns the decoder to its reset state.
// An accepted byte is classified and written into a four-entry queue; the
// framing state machine takes one byte per cycle from the queue whenever the
// output register is empty or not stalled, and registers its result there.
// Sustained throughput is one byte per cycle while the receiver does not
// stall, set by the per-byte update of the framing state and chunk counter.
// When the receiver stalls, the output register holds its item, the queue
// fills, and o_in_stall rises once all four entries are in use.
// Reset is synchronous and active low; it empties the queue and the output
// register and starts a new size line.
`default_nettype none
module http_chunked_body_decoder #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hcbd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hcbd_pkg::t_out_item o_out_item
);
    import hcbd_pkg::*;

`include "http_chunked_body_decoder_assert.svh"

    t_class  front_class;
    t_class  q_class;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    hcbd_front u_front (
        .i_valid  (i_in_valid),
        .i_item   (i_in_item),
        .i_q_full (q_stat.full),
        .o_stall  (o_in_stall),
        .o_push   (q_push),
        .o_class  (front_class)
    );

    hcbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_class (front_class),
        .i_pop   (q_pop),
        .o_class (q_class),
        .o_stat  (q_stat)
    );

    hcbd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_class     (q_class),
        .i_q_empty   (q_stat.empty),
        .i_out_stall (i_out_stall),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `HCBD_ASSERT_SAME(a_payload_zero, o_out_valid && (o_out_item.status != ST_DATA), o_out_item.payload_byte == 8'h00)
    `HCBD_ASSERT_SAME(a_status_range, o_out_valid, o_out_item.status <= ST_NO_DATA_TERM)
    `HCBD_ASSERT_SAME(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty))
    `HCBD_ASSERT_NEXT(a_queue_fill, q_push && q_stat.empty, !q_stat.empty)

endmodule
`default_nettype wire

### rtl/hcbd_front.sv
// Input handshake and byte classification ahead of the queue.
`default_nettype none
module hcbd_front (
    input  logic              i_valid,
    input  hcbd_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_stall,
    output logic              o_push,
    output hcbd_pkg::t_class  o_class
);
    import hcbd_pkg::*;

    logic [7:0] b;

    assign b       = i_item.body_byte;
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_class.body_byte = b;
        o_class.last      = i_item.end_of_body;
        o_class.is_cr     = (b == CHAR_CR);
        o_class.is_lf     = (b == CHAR_LF);
        o_class.is_semi   = (b == CHAR_SEMI);
        o_class.is_hex    = 1'b0;
        o_class.hex_val   = 4'h0;
        if (b inside {[8'h30:8'h39]}) begin
            o_class.is_hex  = 1'b1;
            o_class.hex_val = 4'(b - 8'h30);
        end else if (b inside {[8'h61:8'h66]}) begin
            o_class.is_hex  = 1'b1;
            o_class.hex_val = 4'(b - 8'h57);
        end else if (b inside {[8'h41:8'h46]}) begin
            o_class.is_hex  = 1'b1;
            o_class.hex_val = 4'(b - 8'h37);
        end
    end

endmodule
`default_nettype wire

### rtl/hcbd_queue.sv
// Short queue of classified bytes between the front and back parts.
`default_nettype none
module hcbd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hcbd_pkg::t_class i_class,
    input  logic             i_pop,
    output hcbd_pkg::t_class o_class,
    output hcbd_pkg::t_q_stat o_stat
);
    import hcbd_pkg::*;

    t_class            r_slot [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_fill;
    logic [Q_AW:0]     n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + (Q_AW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_class;
        end
    end

    assign o_class      = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_fill == '0);

endmodule
`default_nettype wire

### rtl/hcbd_back.sv
// Chunk framing state machine and registered result stage.
`default_nettype none
module hcbd_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hcbd_pkg::t_class    i_class,
    input  logic                i_q_empty,
    input  logic                i_out_stall,
    output logic                o_pop,
    output logic                o_out_valid,
    output hcbd_pkg::t_out_item o_out_item
);
    import hcbd_pkg::*;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_digit;
    logic                   n_digit;
    logic                   r_inv;
    logic                   n_inv;
    logic                   r_tbad;
    logic                   n_tbad;
    logic                   r_stopped;
    logic                   n_stopped;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   ready;
    logic                   inv_in;
    t_phase                 sb_phase;
    logic [COUNT_WIDTH-1:0] sb_count;
    logic                   sb_digit;
    logic                   sb_inv;
    logic                   line_bad;
    logic                   count_zero;
    logic                   res_valid;
    logic [2:0]             res_status;
    logic [7:0]             res_byte;

    assign ready      = !r_out_valid || !i_out_stall;
    assign o_pop      = ready && !i_q_empty;
    assign line_bad   = r_inv || !r_digit;
    assign count_zero = (r_count == '0);
    assign inv_in     = r_inv || (r_phase == PH_SIZE_CR);

    // Effect of one byte on an open size line.
    always_comb begin
        sb_phase = PH_SIZE;
        sb_count = r_count;
        sb_digit = r_digit;
        sb_inv   = inv_in;
        if (i_class.is_cr) begin
            sb_phase = PH_SIZE_CR;
        end else if (i_class.is_semi) begin
            sb_phase = PH_EXT;
        end else if (!i_class.is_hex) begin
            sb_inv = 1'b1;
        end else begin
            sb_digit = 1'b1;
            if (!inv_in) begin
                if (|r_count[COUNT_WIDTH-1 -: 4]) begin
                    sb_inv = 1'b1;
                end else begin
                    sb_count = {r_count[COUNT_WIDTH-5:0], i_class.hex_val};
                end
            end
        end
    end

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_digit   = r_digit;
        n_inv     = r_inv;
        n_tbad    = r_tbad;
        n_stopped = r_stopped;
        if (o_pop) begin
            if (!r_stopped) begin
                case (r_phase)
                    PH_SIZE_CR, PH_EXT_CR: begin
                        if (i_class.is_lf) begin
                            if (line_bad || count_zero) begin
                                n_stopped = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end else if (r_phase == PH_SIZE_CR) begin
                            n_phase = sb_phase;
                            n_count = sb_count;
                            n_digit = sb_digit;
                            n_inv   = sb_inv;
                        end else begin
                            n_phase = i_class.is_cr ? PH_EXT_CR : PH_EXT;
                        end
                    end
                    PH_EXT: begin
                        n_phase = i_class.is_cr ? PH_EXT_CR : PH_EXT;
                    end
                    PH_DATA: begin
                        if (!i_class.last) begin
                            n_count = r_count - COUNT_WIDTH'(1);
                            if (r_count == COUNT_WIDTH'(1)) begin
                                n_phase = PH_TERM1;
                            end
                        end
                    end
                    PH_TERM1: begin
                        n_tbad  = !i_class.is_cr;
                        n_phase = PH_TERM2;
                    end
                    PH_TERM2: begin
                        if (r_tbad || !i_class.is_lf) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_phase = PH_SIZE;
                            n_count = '0;
                            n_digit = 1'b0;
                            n_inv   = 1'b0;
                            n_tbad  = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = sb_phase;
                        n_count = sb_count;
                        n_digit = sb_digit;
                        n_inv   = sb_inv;
                    end
                endcase
            end
            if (i_class.last) begin
                n_phase   = PH_SIZE;
                n_count   = '0;
                n_digit   = 1'b0;
                n_inv     = 1'b0;
                n_tbad    = 1'b0;
                n_stopped = 1'b0;
            end
        end
    end

    // Result of the byte being taken from the queue.
    always_comb begin
        res_valid  = 1'b0;
        res_status = ST_DATA;
        res_byte   = 8'h00;
        if (o_pop && !r_stopped) begin
            case (r_phase)
                PH_SIZE_CR, PH_EXT_CR: begin
                    if (i_class.is_lf) begin
                        if (line_bad) begin
                            res_valid  = 1'b1;
                            res_status = ST_BAD_SIZE;
                        end else if (count_zero) begin
                            res_valid  = 1'b1;
                            res_status = ST_FINISHED;
                        end else if (i_class.last) begin
                            res_valid  = 1'b1;
                            res_status = ST_TRUNCATED;
                        end
                    end else if (i_class.last) begin
                        res_valid  = 1'b1;
                        res_status = ST_NO_SIZE_TERM;
                    end
                end
                PH_DATA: begin
                    res_valid = 1'b1;
                    if (i_class.last) begin
                        res_status = ST_TRUNCATED;
                    end else begin
                        res_byte = i_class.body_byte;
                    end
                end
                PH_TERM1: begin
                    if (i_class.last) begin
                        res_valid  = 1'b1;
                        res_status = ST_TRUNCATED;
                    end
                end
                PH_TERM2: begin
                    if (r_tbad || !i_class.is_lf) begin
                        res_valid  = 1'b1;
                        res_status = ST_NO_DATA_TERM;
                    end else if (i_class.last) begin
                        res_valid  = 1'b1;
                        res_status = ST_NO_SIZE_TERM;
                    end
                end
                default: begin
                    if (i_class.last) begin
                        res_valid  = 1'b1;
                        res_status = ST_NO_SIZE_TERM;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_count     <= '0;
            r_digit     <= 1'b0;
            r_inv       <= 1'b0;
            r_tbad      <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_digit   <= n_digit;
            r_inv     <= n_inv;
            r_tbad    <= n_tbad;
            r_stopped <= n_stopped;
            if (ready) begin
                r_out_valid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready) begin
            r_out_item.payload_byte <= res_byte;
            r_out_item.status       <= res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the HTTP chunked body decoder: directed table plus random bodies.
`timescale 1ns / 100ps
module tb_top;
    import hcbd_pkg::*;

    localparam int COUNT_W    = 32;
    localparam int N_ITEMS    = 1700;
    localparam int IDLE_LIMIT = 1000;
    localparam int MAX_SHOWN  = 10;

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_NONE,
        EXP_STATUS,
        EXP_DATA
    } t_check_kind;

    typedef struct packed {
        logic [7:0]  b;
        logic        eob;
        t_check_kind kind;
        logic [2:0]  status;
    } t_dir_row;

    typedef struct {
        t_in_item    item;
        t_check_kind kind;
        logic [2:0]  status;
        bit          drain;
    } t_stim;

    localparam t_dir_row DIRECTED [26] = '{
        '{"1",       1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_CR,   1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_LF,   1'b0, EXP_PREDICT, ST_DATA},
        '{8'h00,     1'b0, EXP_DATA,    ST_DATA},
        '{CHAR_CR,   1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_LF,   1'b0, EXP_PREDICT, ST_DATA},
        '{"0",       1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_CR,   1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_LF,   1'b1, EXP_STATUS,  ST_FINISHED},
        '{CHAR_SEMI, 1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_CR,   1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_LF,   1'b0, EXP_STATUS,  ST_BAD_SIZE},
        '{8'hFF,     1'b1, EXP_NONE,    ST_DATA},
        '{"b",       1'b1, EXP_STATUS,  ST_NO_SIZE_TERM},
        '{"1",       1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_SEMI, 1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_CR,   1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_LF,   1'b0, EXP_PREDICT, ST_DATA},
        '{8'hFF,     1'b1, EXP_STATUS,  ST_TRUNCATED},
        '{"1",       1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_CR,   1'b0, EXP_PREDICT, ST_DATA},
        '{CHAR_LF,   1'b0, EXP_PREDICT, ST_DATA},
        '{8'hFF,     1'b0, EXP_DATA,    ST_DATA},
        '{"x",       1'b0, EXP_PREDICT, ST_DATA},
        '{"y",       1'b0, EXP_STATUS,  ST_NO_DATA_TERM},
        '{CHAR_LF,   1'b1, EXP_NONE,    ST_DATA}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    http_chunked_body_decoder #(
        .COUNT_WIDTH(COUNT_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    t_stim     body_q[$];
    t_out_item pending_q[$];
    int        send_idx    = 0;
    int        burst_left  = 0;
    int        gap_left    = 0;
    int        idle_cycles = 0;
    int        errors      = 0;
    int        results     = 0;
    int        bodies      = 0;
    int        status_seen[8];
    int        rx_cycle    = 0;
    int        stall_mode  = 0;
    int        stall_run   = 0;

    // Decoder state as the predictor sees it.
    t_phase             line_phase;
    logic [COUNT_W-1:0] chunk_count;
    bit                 digit_seen;
    bit                 size_bad;
    bit                 term_bad;
    bit                 halted;

    function automatic void start_line();
        line_phase  = PH_SIZE;
        chunk_count = '0;
        digit_seen  = 1'b0;
        size_bad    = 1'b0;
        term_bad    = 1'b0;
    endfunction

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") v = 4'(c - "0");
        else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 10) return 8'("0" + d);
        return ($urandom_range(0, 1) != 0) ? 8'("a" + d - 10) : 8'("A" + d - 10);
    endfunction

    function automatic void size_char(input logic [7:0] c);
        logic [3:0] v;
        bit         ok;
        ok = hex_digit(c, v);
        if (c == CHAR_CR) begin
            line_phase = PH_SIZE_CR;
        end else if (c == CHAR_SEMI) begin
            line_phase = PH_EXT;
        end else begin
            line_phase = PH_SIZE;
            if (!ok) begin
                size_bad = 1'b1;
            end else begin
                digit_seen = 1'b1;
                if (!size_bad) begin
                    if (chunk_count[COUNT_W-1 -: 4] != 4'd0) size_bad = 1'b1;
                    else chunk_count = {chunk_count[COUNT_W-5:0], v};
                end
            end
        end
    endfunction

    function automatic void close_line(input bit last, output bit has_res,
                                       output logic [2:0] st);
        has_res = 1'b1;
        st      = ST_DATA;
        if (size_bad || !digit_seen) begin
            halted = 1'b1;
            st     = ST_BAD_SIZE;
        end else if (chunk_count == '0) begin
            halted = 1'b1;
            st     = ST_FINISHED;
        end else if (last) begin
            st = ST_TRUNCATED;
        end else begin
            has_res    = 1'b0;
            line_phase = PH_DATA;
        end
    endfunction

    function automatic void decode_byte(input t_in_item it, output bit has_res,
                                        output t_out_item res);
        logic [7:0] c;
        bit         last;
        logic [2:0] st;
        c       = it.body_byte;
        last    = it.end_of_body;
        has_res = 1'b0;
        st      = ST_DATA;
        res     = '0;
        if (!halted) begin
            case (line_phase)
                PH_SIZE_CR: begin
                    if (c == CHAR_LF) begin
                        close_line(last, has_res, st);
                    end else begin
                        size_bad = 1'b1;
                        size_char(c);
                        if (last) begin
                            has_res = 1'b1;
                            st      = ST_NO_SIZE_TERM;
                        end
                    end
                end
                PH_EXT, PH_EXT_CR: begin
                    if (line_phase == PH_EXT_CR && c == CHAR_LF) begin
                        close_line(last, has_res, st);
                    end else begin
                        line_phase = (c == CHAR_CR) ? PH_EXT_CR : PH_EXT;
                        if (last) begin
                            has_res = 1'b1;
                            st      = ST_NO_SIZE_TERM;
                        end
                    end
                end
                PH_DATA: begin
                    has_res = 1'b1;
                    if (last) begin
                        st = ST_TRUNCATED;
                    end else begin
                        res.payload_byte = c;
                        chunk_count      = chunk_count - 1'b1;
                        if (chunk_count == '0) line_phase = PH_TERM1;
                    end
                end
                PH_TERM1: begin
                    term_bad   = (c != CHAR_CR);
                    line_phase = PH_TERM2;
                    if (last) begin
                        has_res = 1'b1;
                        st      = ST_TRUNCATED;
                    end
                end
                PH_TERM2: begin
                    has_res = 1'b1;
                    if (term_bad || c != CHAR_LF) begin
                        halted = 1'b1;
                        st     = ST_NO_DATA_TERM;
                    end else begin
                        start_line();
                        has_res = last;
                        st      = ST_NO_SIZE_TERM;
                    end
                end
                default: begin
                    size_char(c);
                    if (last) begin
                        has_res = 1'b1;
                        st      = ST_NO_SIZE_TERM;
                    end
                end
            endcase
        end
        if (last) begin
            start_line();
            halted = 1'b0;
        end
        res.status = st;
    endfunction

    function automatic void put_size_line(ref logic [7:0] bq[$], input logic [31:0] sz);
        int lead;
        int k;
        bit started;
        started = 1'b0;
        lead    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        repeat (lead) bq = {bq, 8'h30};
        for (k = 7; k >= 0; k--) begin
            if (sz[k*4 +: 4] != 4'd0 || started || k == 0) begin
                started = 1'b1;
                bq = {bq, hex_char(sz[k*4 +: 4])};
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            bq = {bq, CHAR_SEMI};
            repeat ($urandom_range(0, 6)) begin
                bq = {bq, (($urandom_range(0, 9) == 0) ? CHAR_CR
                                                       : 8'($urandom_range(8'h20, 8'h7E)))};
            end
        end
        bq = {bq, CHAR_CR};
        bq = {bq, CHAR_LF};
    endfunction

    task automatic gen_body(input bit drain_first);
        logic [7:0]  bq[$];
        logic [31:0] sz;
        t_stim       s;
        int          mode;
        int          k;
        mode = $urandom_range(0, 19);
        if (mode < 2) begin
            repeat ($urandom_range(1, 12)) bq = {bq, 8'($urandom_range(0, 255))};
        end else if (mode == 2) begin
            bq = {bq, 8'h31};
            repeat ($urandom_range(8, 9)) bq = {bq, hex_char(4'($urandom_range(0, 15)))};
            bq = {bq, CHAR_CR};
            bq = {bq, CHAR_LF};
            bq = {bq, 8'($urandom_range(0, 255))};
        end else if (mode == 3) begin
            put_size_line(bq, 32'hFFFF_FFFF);
            repeat ($urandom_range(1, 5)) bq = {bq, 8'($urandom_range(0, 255))};
        end else begin
            repeat ($urandom_range(0, 3)) begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                put_size_line(bq, sz);
                repeat (sz) bq = {bq, 8'($urandom_range(0, 255))};
                bq = {bq, CHAR_CR};
                bq = {bq, CHAR_LF};
            end
            put_size_line(bq, 32'd0);
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 8)) bq = {bq, 8'($urandom_range(8'h20, 8'h7E))};
                bq = {bq, CHAR_CR};
                bq = {bq, CHAR_LF};
            end
            bq = {bq, CHAR_CR};
            bq = {bq, CHAR_LF};
            if (mode < 6) bq[$urandom_range(0, bq.size() - 1)] = 8'($urandom_range(0, 255));
            else if (mode < 9) bq = bq[0 : $urandom_range(0, bq.size() - 1)];
        end
        for (k = 0; k < bq.size(); k++) begin
            s.item.body_byte   = bq[k];
            s.item.end_of_body = (k == bq.size() - 1);
            s.kind             = EXP_PREDICT;
            s.status           = ST_DATA;
            s.drain            = drain_first && (k == 0);
            body_q = {body_q, s};
        end
        bodies++;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        bit        has_res;
        bit        moved;
        bit        stall_next;
        t_out_item res;
        t_out_item want;
        moved = 1'b0;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(body_q[send_idx].item, has_res, res);
                case (body_q[send_idx].kind)
                    EXP_PREDICT: if (has_res) pending_q = {pending_q, res};
                    EXP_STATUS: begin
                        want.payload_byte = 8'h00;
                        want.status       = body_q[send_idx].status;
                        pending_q = {pending_q, want};
                    end
                    EXP_DATA: begin
                        want.payload_byte = body_q[send_idx].item.body_byte;
                        want.status       = ST_DATA;
                        pending_q = {pending_q, want};
                    end
                    default: ;
                endcase
                send_idx++;
                moved = 1'b1;
            end

            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results++;
                status_seen[o_out_item.status]++;
                if (pending_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%0t: unexpected result payload=%02h status=%0d", $time,
                                 o_out_item.payload_byte, o_out_item.status);
                end else begin
                    want = pending_q.pop_front();
                    if (o_out_item.payload_byte !== want.payload_byte ||
                        o_out_item.status !== want.status) begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display("%0t: mismatch expected payload=%02h status=%0d, got %02h %0d",
                                     $time, want.payload_byte, want.status,
                                     o_out_item.payload_byte, o_out_item.status);
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;

            if (!(i_in_valid && o_in_stall)) begin
                if (send_idx >= body_q.size() || gap_left > 0 ||
                    (body_q[send_idx].drain && pending_q.size() != 0)) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= body_q[send_idx].item;
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 9) < 2) begin
                            burst_left = $urandom_range(50, 200);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(0, 5);
                        end
                    end else begin
                        burst_left--;
                    end
                end
            end

            rx_cycle++;
            if (rx_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = (rx_cycle % 5 < 2);
                3: begin
                    if (stall_run > 0) begin
                        stall_run--;
                        stall_next = 1'b1;
                    end else begin
                        stall_next = 1'b0;
                        if ($urandom_range(0, 15) == 0) stall_run = $urandom_range(5, 20);
                    end
                end
                default: stall_next = 1'b0;
            endcase
            if (send_idx >= body_q.size() && pending_q.size() == 0) stall_next = 1'b0;
            i_out_stall <= stall_next;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no item moved for %0d cycles, %0d results still expected",
                 IDLE_LIMIT, pending_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_stim s;
        start_line();
        halted = 1'b0;
        foreach (DIRECTED[i]) begin
            s.item.body_byte   = DIRECTED[i].b;
            s.item.end_of_body = DIRECTED[i].eob;
            s.kind             = DIRECTED[i].kind;
            s.status           = DIRECTED[i].status;
            s.drain            = 1'b0;
            body_q = {body_q, s};
        end
        gen_body(1'b1);
        while (body_q.size() < N_ITEMS) gen_body($urandom_range(0, 99) == 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (send_idx < body_q.size() || pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d body bytes in %0d bodies; checked %0d results, %0d mismatches.",
                 send_idx, bodies, results, errors);
        $display("Results by status: data %0d, finished %0d, no size CRLF %0d, bad size %0d, "
                 , status_seen[ST_DATA], status_seen[ST_FINISHED],
                 status_seen[ST_NO_SIZE_TERM], status_seen[ST_BAD_SIZE]);
        $display("  truncated %0d, no data CRLF %0d.", status_seen[ST_TRUNCATED],
                 status_seen[ST_NO_DATA_TERM]);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/hcbd_pkg.sv
rtl/hcbd_front.sv
rtl/hcbd_queue.sv
rtl/hcbd_back.sv
rtl/http_chunked_body_decoder.sv
tb/tb_top.sv
